// File: rtl/pwl_pkg.sv
package pwl_pkg;

	// Default table size and breakpoint width (signed Q16.16)
	localparam int TABLE_DEPTH = 64;
	localparam int VALUE_WIDTH = 32;

	// Item kinds
	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_SEARCH = 2'd1;
	localparam logic [1:0] KIND_DIRECT = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_RANGE  = 2'd1;
	localparam logic [1:0] ST_BADSEG = 2'd2;
	localparam logic [1:0] ST_ZERO   = 2'd3;

endpackage

// File: rtl/piecewise_linear_table_interp_unit.sv
// Channel  | handshake                     | payload
// ---------+-------------------------------+----------------------------------------------
// in       | in_valid / in_ready           | kind, entry_index, point_x, point_y,
//          |                               | query_x, segment_hint
// out      | out_valid / out_ready         | y_result, segment_index, status
// cfg      | cfg_wr_en (no wait)           | cfg_wr_data (table_length)
//
// One item at a time. Load and reserved kinds go straight to the finish state; a direct query
// with a valid hint runs the radix-2 divider (one quotient bit a cycle).
// A search adds 2 range reads plus one read per entry on the walk down and up from
// the middle entry on the single read port of the breakpoint memory.
// Reset clears the sequencer and the output valid and sets the length register to 2;
// the table is undefined until loaded.
// A new item is taken while a finished result waits in the output register; the next
// result waits in its last state until that register is free.

module piecewise_linear_table_interp_unit #(
	parameter int TABLE_DEPTH = pwl_pkg::TABLE_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_wr_en,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0]     cfg_wr_data,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           kind,
	input  logic [$clog2(TABLE_DEPTH)-1:0]       entry_index,
	input  logic signed [pwl_pkg::VALUE_WIDTH-1:0] point_x,
	input  logic signed [pwl_pkg::VALUE_WIDTH-1:0] point_y,
	input  logic signed [pwl_pkg::VALUE_WIDTH-1:0] query_x,
	input  logic [$clog2(TABLE_DEPTH)-1:0]       segment_hint,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [pwl_pkg::VALUE_WIDTH-1:0] y_result,
	output logic [$clog2(TABLE_DEPTH)-1:0]       segment_index,
	output logic [1:0]                           status
);

	localparam int VW = pwl_pkg::VALUE_WIDTH;
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int LW = $clog2(TABLE_DEPTH + 1);
	localparam int PW = 2 * VW + 1;
	localparam int NW = 2 * VW + 2;
	localparam int CW = $clog2(VW);

	typedef enum logic [14:0] {
		S_IDLE = 15'b000000000000001,
		S_LO   = 15'b000000000000010,
		S_HI   = 15'b000000000000100,
		S_DN   = 15'b000000000001000,
		S_UP   = 15'b000000000010000,
		S_P0   = 15'b000000000100000,
		S_P1   = 15'b000000001000000,
		S_M1   = 15'b000000010000000,
		S_M2   = 15'b000000100000000,
		S_SUM  = 15'b000001000000000,
		S_ABS  = 15'b000010000000000,
		S_CHK  = 15'b000100000000000,
		S_DIV  = 15'b001000000000000,
		S_SAT  = 15'b010000000000000,
		S_FIN  = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;

	// control registers
	logic [LW-1:0] len_cfg_q;
	logic          out_valid_q;

	// datapath registers
	logic signed [VW-1:0]   q_q;
	logic [IW-1:0]          i_q;
	logic                   lo_fail_q;
	logic signed [VW-1:0]   x0_q, y0_q, y1_q;
	logic signed [VW:0]     a1_q, a0_q;
	logic                   d_neg_q;
	logic [VW-1:0]          dm_q;
	logic signed [PW-1:0]   p1_q, p0_q;
	logic signed [NW-1:0]   num_q;
	logic [2*VW-1:0]        mag_q;
	logic                   neg_q;
	logic [VW-1:0]          rem_q, dq_q;
	logic [CW-1:0]          cnt_q;
	logic [VW-1:0]          res_y_q;
	logic [IW-1:0]          res_seg_q;
	logic [1:0]             res_st_q;
	logic [VW-1:0]          y_out_q;
	logic [IW-1:0]          seg_out_q;
	logic [1:0]             st_out_q;

	// breakpoint memory: {x, y} per entry, registered read
	logic [2*VW-1:0] mem [TABLE_DEPTH];
	logic [2*VW-1:0] rd_q;
	logic            rd_en;
	logic [IW-1:0]   rd_addr;
	logic            mem_we;

	logic signed [VW-1:0] rd_x, rd_y;
	logic [LW-1:0]        len_c, len_m1, len_m2, len_half;
	logic                 in_acc, fin_go;
	logic                 slot_ok, hint_bad;
	logic                 lo_lt, hi_gt, dn_go, up_go;
	logic [IW-1:0]        seg_c;
	logic signed [VW:0]   d_full, d_negv;
	logic                 d_zero;
	logic [VW-1:0]        d_mag;
	logic signed [VW-1:0] mul_a;
	logic signed [VW:0]   mul_b;
	logic signed [PW-1:0] mul_p;
	logic signed [NW-1:0] sum_c, num_negv;
	logic [2*VW-1:0]      mag_c;
	logic                 ovf;
	logic [VW:0]          sh, sh_sub;
	logic                 ge;
	logic [VW-1:0]        sat_lim, qs, y_fin;

	assign rd_x = rd_q[2*VW-1:VW];
	assign rd_y = rd_q[VW-1:0];

	// effective table length, clamped to [2, TABLE_DEPTH]
	always_comb begin
		if (len_cfg_q < LW'(2)) begin
			len_c = LW'(2);
		end else if (len_cfg_q > LW'(TABLE_DEPTH)) begin
			len_c = LW'(TABLE_DEPTH);
		end else begin
			len_c = len_cfg_q;
		end
	end
	assign len_m1   = len_c - LW'(1);
	assign len_m2   = len_c - LW'(2);
	assign len_half = len_c >> 1;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign fin_go   = !out_valid_q || out_ready;
	assign slot_ok  = (IW+1)'(entry_index) < (IW+1)'(TABLE_DEPTH);
	assign hint_bad = LW'(segment_hint) > len_m2;
	assign mem_we   = in_acc && (kind == pwl_pkg::KIND_LOAD) && slot_ok;

	// search compares against the entry read last cycle
	assign lo_lt = q_q < rd_x;
	assign hi_gt = q_q > rd_x;
	assign dn_go = (i_q != '0) && lo_lt;
	assign up_go = (((LW+1)'(i_q) + (LW+1)'(3)) <= (LW+1)'(len_c)) && hi_gt;
	assign seg_c = (LW'(i_q) > len_m2) ? IW'(len_m2) : i_q;

	// segment width and its magnitude
	assign d_full = {rd_x[VW-1], rd_x} - {x0_q[VW-1], x0_q};
	assign d_negv = -d_full;
	assign d_zero = (d_full == '0);
	assign d_mag  = d_full[VW] ? d_negv[VW-1:0] : d_full[VW-1:0];

	// one shared multiplier for both products
	assign mul_a = (state_q == S_M1) ? y1_q : y0_q;
	assign mul_b = (state_q == S_M1) ? a1_q : a0_q;
	assign mul_p = mul_a * mul_b;

	// numerator sum and magnitude (fits 2*VW bits)
	assign sum_c    = NW'(p1_q) + NW'(p0_q);
	assign num_negv = -num_q;
	assign mag_c    = num_q[NW-1] ? num_negv[2*VW-1:0] : num_q[2*VW-1:0];

	// quotient needs more than VW bits when the high half reaches the divisor
	assign ovf = mag_q[2*VW-1:VW] >= dm_q;

	// restoring divider step
	assign sh     = {rem_q, dq_q[VW-1]};
	assign sh_sub = sh - {1'b0, dm_q};
	assign ge     = sh >= {1'b0, dm_q};

	// saturation limit; for a negative result it is also the final bit pattern
	assign sat_lim = neg_q ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
	assign qs      = (dq_q > sat_lim) ? sat_lim : dq_q;
	assign y_fin   = neg_q ? (VW'(0) - qs) : qs;

	// sequencer and read-port control
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (kind)
						pwl_pkg::KIND_SEARCH: begin
							rd_en   = 1'b1;
							state_d = S_LO;
						end
						pwl_pkg::KIND_DIRECT: begin
							if (hint_bad) begin
								state_d = S_FIN;
							end else begin
								rd_en   = 1'b1;
								rd_addr = segment_hint;
								state_d = S_P0;
							end
						end
						default: state_d = S_FIN;
					endcase
				end
			end
			S_LO: begin
				rd_en   = 1'b1;
				rd_addr = IW'(len_m1);
				state_d = S_HI;
			end
			S_HI: begin
				if (lo_fail_q || hi_gt) begin
					state_d = S_FIN;
				end else begin
					rd_en   = 1'b1;
					rd_addr = IW'(len_half);
					state_d = S_DN;
				end
			end
			S_DN: begin
				rd_en = 1'b1;
				if (dn_go) begin
					rd_addr = i_q - IW'(1);
				end else begin
					rd_addr = i_q + IW'(1);
					state_d = S_UP;
				end
			end
			S_UP: begin
				rd_en = 1'b1;
				if (up_go) begin
					rd_addr = i_q + IW'(2);
				end else begin
					rd_addr = seg_c;
					state_d = S_P0;
				end
			end
			S_P0: begin
				rd_en   = 1'b1;
				rd_addr = i_q + IW'(1);
				state_d = S_P1;
			end
			S_P1:  state_d = d_zero ? S_FIN : S_M1;
			S_M1:  state_d = S_M2;
			S_M2:  state_d = S_SUM;
			S_SUM: state_d = S_ABS;
			S_ABS: state_d = S_CHK;
			S_CHK: state_d = ovf ? S_FIN : S_DIV;
			S_DIV: begin
				if (cnt_q == CW'(VW - 1)) begin
					state_d = S_SAT;
				end
			end
			S_SAT: state_d = S_FIN;
			S_FIN: begin
				if (fin_go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			len_cfg_q   <= LW'(2);
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				len_cfg_q <= cfg_wr_data;
			end
			if (state_q == S_FIN && fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// breakpoint memory; loads and reads never fall in the same cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[entry_index] <= {point_x, point_y};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					q_q       <= query_x;
					i_q       <= segment_hint;
					res_y_q   <= '0;
					res_seg_q <= '0;
					res_st_q  <= pwl_pkg::ST_OK;
					if (kind == pwl_pkg::KIND_DIRECT && hint_bad) begin
						res_st_q <= pwl_pkg::ST_BADSEG;
					end
				end
			end
			S_LO: lo_fail_q <= lo_lt;
			S_HI: begin
				i_q <= IW'(len_half);
				if (lo_fail_q || hi_gt) begin
					res_st_q <= pwl_pkg::ST_RANGE;
				end
			end
			S_DN: begin
				if (dn_go) begin
					i_q <= i_q - IW'(1);
				end
			end
			S_UP: begin
				if (up_go) begin
					i_q <= i_q + IW'(1);
				end else begin
					i_q <= seg_c;
				end
			end
			S_P0: begin
				x0_q <= rd_x;
				y0_q <= rd_y;
			end
			S_P1: begin
				y1_q      <= rd_y;
				a1_q      <= {q_q[VW-1], q_q} - {x0_q[VW-1], x0_q};
				a0_q      <= {rd_x[VW-1], rd_x} - {q_q[VW-1], q_q};
				d_neg_q   <= d_full[VW];
				dm_q      <= d_mag;
				res_seg_q <= i_q;
				if (d_zero) begin
					res_st_q <= pwl_pkg::ST_ZERO;
				end
			end
			S_M1:  p1_q  <= mul_p;
			S_M2:  p0_q  <= mul_p;
			S_SUM: num_q <= sum_c;
			S_ABS: begin
				mag_q <= mag_c;
				neg_q <= num_q[NW-1] ^ d_neg_q;
			end
			S_CHK: begin
				rem_q <= mag_q[2*VW-1:VW];
				dq_q  <= mag_q[VW-1:0];
				cnt_q <= '0;
				if (ovf) begin
					res_y_q <= sat_lim;
				end
			end
			S_DIV: begin
				rem_q <= ge ? sh_sub[VW-1:0] : sh[VW-1:0];
				dq_q  <= {dq_q[VW-2:0], ge};
				cnt_q <= cnt_q + CW'(1);
			end
			S_SAT: res_y_q <= y_fin;
			S_FIN: begin
				if (fin_go) begin
					y_out_q   <= res_y_q;
					seg_out_q <= res_seg_q;
					st_out_q  <= res_st_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign y_result      = y_out_q;
	assign segment_index = seg_out_q;
	assign status        = st_out_q;

`ifndef SYNTHESIS
	// sequencer stays one-hot
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	// divider remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < dm_q))
		else $error("divider remainder out of range");

	// finished segment index lies inside the table
	a_seg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> (LW'(res_seg_q) <= len_m2))
		else $error("segment index beyond table");

	// error results carry a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && res_st_q != pwl_pkg::ST_OK) |-> (res_y_q == '0))
		else $error("error result with nonzero value");
`endif

endmodule
